>>> hw/rtl/cbp_pkg.sv
// ----------------------------------------------------------------------------
// Coefficient bit packer package
// Shared word types and constants for the packer front, queue and back.
// ----------------------------------------------------------------------------
package cbp_pkg;

    // Field widths.
    localparam int COEFF_W = 64;
    localparam int WIDTH_W = 7;
    localparam int BYTE_W  = 8;

    // The bit buffer holds up to seven leftover bits plus one full coefficient.
    localparam int BUF_W = COEFF_W + BYTE_W;
    localparam int REM_W = 7;

    // Coefficient width limits and the value after reset.
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 7'd1;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 7'd64;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd8;

    // Input word.
    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic               final_coeff;
    } in_t;

    // Result word.
    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              run_end;
        logic              stream_end;
    } out_t;

    // Classified job handed from the front to the back.
    typedef struct packed {
        logic [COEFF_W-1:0] bits;        // coefficient, left aligned, masked
        logic [WIDTH_W-1:0] width;       // effective width, 1 to 64
        logic               final_coeff;
    } job_t;

endpackage

>>> hw/rtl/cbp_front.sv
// ----------------------------------------------------------------------------
// Coefficient bit packer front
// Holds the width register, accepts words and turns each into a job with the
// coefficient left aligned and its unused bits cleared.
// ----------------------------------------------------------------------------
module cbp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  cbp_pkg::in_t                  item,
    input  logic                          cfg_we,
    input  logic [cbp_pkg::WIDTH_W-1:0]   cfg_data,
    input  logic                          q_full,
    output logic                          q_push,
    output cbp_pkg::job_t                 q_job
);

    logic [cbp_pkg::WIDTH_W-1:0] width_reg;
    logic [cbp_pkg::WIDTH_W-1:0] width_eff;
    logic [5:0]                  align_shift;

    // Width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= cbp_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            width_reg <= cfg_data;
        end
    end

    // Clamp the width into its legal range.
    always_comb
    begin
        if (width_reg < cbp_pkg::WIDTH_MIN)
        begin
            width_eff = cbp_pkg::WIDTH_MIN;
        end
        else if (width_reg > cbp_pkg::WIDTH_MAX)
        begin
            width_eff = cbp_pkg::WIDTH_MAX;
        end
        else
        begin
            width_eff = width_reg;
        end
    end

    // Shifting left by 64 minus the width drops the unused upper bits.
    assign align_shift = 6'(cbp_pkg::WIDTH_MAX - width_eff);

    always_comb
    begin
        q_job.bits        = item.coeff << align_shift;
        q_job.width       = width_eff;
        q_job.final_coeff = item.final_coeff;
    end

    // Handshake toward the job queue.
    assign full   = q_full;
    assign q_push = push && !q_full;

endmodule

>>> hw/rtl/cbp_queue.sv
// ----------------------------------------------------------------------------
// Coefficient bit packer job queue
// A short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cbp_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbp_pkg::job_t  wr_job,
    output logic           full,
    input  logic           pop,
    output cbp_pkg::job_t  rd_job,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbp_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/cbp_back.sv
// ----------------------------------------------------------------------------
// Coefficient bit packer back
// Loads jobs into a left-aligned bit buffer; unless the receiver stalls, emits
// one byte per cycle into the result register, flushing leftovers at stream end.
// ----------------------------------------------------------------------------
module cbp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  cbp_pkg::job_t  q_job,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output cbp_pkg::out_t  result
);

    localparam int BUF_W  = cbp_pkg::BUF_W;
    localparam int BYTE_W = cbp_pkg::BYTE_W;
    localparam int REM_W  = cbp_pkg::REM_W;

    logic [BUF_W-1:0]  buf_reg,  buf_next,  buf_a;
    logic [REM_W-1:0]  rem_reg,  rem_next,  rem_a;
    logic              fin_reg,  fin_next,  fin_a;
    logic              out_valid_reg;
    cbp_pkg::out_t     out_word_reg, out_word_next;

    logic              pending;
    logic              pending_a;
    logic              emit_full;
    logic              out_ready;
    logic              emit;
    logic              load;
    logic [3:0]        flush_shift;
    logic [BYTE_W-1:0] top_byte;

    // Work is pending while a full byte or a final leftover remains.
    assign pending   = (rem_reg >= REM_W'(BYTE_W)) || (fin_reg && (rem_reg != '0));
    assign emit_full = (rem_reg >= REM_W'(BYTE_W));
    assign out_ready = !out_valid_reg || pop;
    assign emit      = pending && out_ready;
    assign top_byte  = buf_reg[BUF_W-1 -: BYTE_W];

    // Leftover bits of a final coefficient move to the low end of the byte.
    assign flush_shift = 4'(BYTE_W) - {1'b0, rem_reg[2:0]};

    // Buffer state after this cycle's byte, before any load.
    always_comb
    begin
        if (emit)
        begin
            if (emit_full)
            begin
                rem_a = rem_reg - REM_W'(BYTE_W);
                buf_a = buf_reg << BYTE_W;
            end
            else
            begin
                rem_a = '0;
                buf_a = '0;
            end
            fin_a = fin_reg && (rem_a != '0);
        end
        else
        begin
            rem_a = rem_reg;
            buf_a = buf_reg;
            fin_a = fin_reg;
        end
    end

    assign pending_a = (rem_a >= REM_W'(BYTE_W)) || (fin_a && (rem_a != '0));
    assign load      = !pending_a && !q_empty;
    assign q_pop     = load;

    // Merge the next job behind the leftover bits.
    always_comb
    begin
        if (load)
        begin
            buf_next = buf_a | ({q_job.bits, {BYTE_W{1'b0}}} >> rem_a[2:0]);
            rem_next = rem_a + q_job.width;
            fin_next = q_job.final_coeff;
        end
        else
        begin
            buf_next = buf_a;
            rem_next = rem_a;
            fin_next = fin_a;
        end
    end

    // Byte and its end marks.
    always_comb
    begin
        out_word_next.packed_byte = emit_full ? top_byte : (top_byte >> flush_shift);
        out_word_next.run_end     = !pending_a;
        out_word_next.stream_end  = fin_reg && !pending_a;
    end

    // Bit buffer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            rem_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            buf_reg <= buf_next;
            rem_reg <= rem_next;
            fin_reg <= fin_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_word_reg;

`ifndef SYNTHESIS
    // A final flag never lingers on an empty buffer.
    a_fin_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        !(fin_reg && (rem_reg == '0)))
        else $error("final flag set with no bits held");

    // The buffer never holds more than leftover bits plus one coefficient.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= REM_W'(BUF_W - 1))
        else $error("bit count exceeds buffer");

    // A job is only merged behind fewer than one byte of leftover bits.
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (rem_a < REM_W'(BYTE_W)))
        else $error("job loaded over a full byte");

    // The last byte of a stream is also the last byte of its coefficient.
    a_stream_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.stream_end) |-> out_word_reg.run_end)
        else $error("stream end without run end");
`endif

endmodule

>>> hw/rtl/coeff_bit_packer.sv
// ----------------------------------------------------------------------------
// Coefficient bit packer
// Packs coefficients of a configured width, most significant bit first, into
// a continuous byte stream.
// ----------------------------------------------------------------------------
// Usage:
// Words enter on push/full/item; a word is taken when push is high and full
// is low. Bytes leave on empty/pop/result; the oldest byte is on result while
// empty is low and is taken when pop is high. cfg_we with cfg_data writes the
// coefficient width (0 acts as 1, above 64 acts as 64); write it only while
// the block is idle.
// A taken word goes through the job queue and the bit buffer; its first byte
// reaches result from the result register. Throughput: while the receiver
// keeps taking bytes, the back end emits one byte per cycle and merges the
// next job in the same cycle as the last byte of the previous one.
// A final word flushes any leftover bits as one more byte, in its low bits.
// Reset empties the job queue and the result register, clears the partial
// byte and sets the width to 8. When the receiver stalls, the result register
// holds, the back end stops, the job queue fills and then full rises.
// ----------------------------------------------------------------------------
module coeff_bit_packer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  cbp_pkg::in_t                  item,
    output logic                          empty,
    input  logic                          pop,
    output cbp_pkg::out_t                 result,
    input  logic                          cfg_we,
    input  logic [cbp_pkg::WIDTH_W-1:0]   cfg_data
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    cbp_pkg::job_t wr_job;
    cbp_pkg::job_t rd_job;

    // Front: width register and word classification.
    cbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (wr_job)
    );

    // Job queue between front and back.
    cbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (wr_job),
        .full   (q_full),
        .pop    (q_pop),
        .rd_job (rd_job),
        .empty  (q_empty)
    );

    // Back: bit buffer and byte output.
    cbp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (rd_job),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
